### rtl/gpio_line_lease_controller_defines.svh
// assertion macros for the gpio line lease controller
`ifndef GPIO_LINE_LEASE_CONTROLLER_DEFINES_SVH
`define GPIO_LINE_LEASE_CONTROLLER_DEFINES_SVH

// same-cycle implication, disabled while reset is high
`define GLLC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define GLLC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/gllc_pkg.sv
// shared types and constants for the gpio line lease controller
`timescale 1ns / 1ps
`default_nettype none
package gllc_pkg;

   localparam int NUM_LINES = 16;
   localparam int LINE_W    = $clog2(NUM_LINES);
   localparam int IDX_W     = 5;
   localparam int MODE_W    = 4;
   localparam int STATUS_W  = 3;
   localparam int BIAS_W    = 2;
   localparam int FAULT_W   = 6;

   typedef enum logic [MODE_W-1:0] {
      MODE_REQUEST  = 4'd0,
      MODE_RELEASE  = 4'd1,
      MODE_DIR_IN   = 4'd2,
      MODE_DIR_OUT  = 4'd3,
      MODE_GET      = 4'd4,
      MODE_SET      = 4'd5,
      MODE_SET_BIAS = 4'd6,
      MODE_DEBOUNCE = 4'd7,
      MODE_INJECT   = 4'd8
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 3'd0,
      ST_RANGE = 3'd1,
      ST_BUSY  = 3'd2,
      ST_FAULT = 3'd3,
      ST_PERM  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      CTRL_IDLE,
      CTRL_EXEC,
      CTRL_RESP
   } ctrl_state_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic capture;
      logic execute;
   } cmd_type;

endpackage
`default_nettype wire

### rtl/gllc_ctrl.sv
// sequencing state machine: capture, execute, hold result for transfer
`timescale 1ns / 1ps
`default_nettype none
module gllc_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output gllc_pkg::cmd_type cmd
);

   gllc_pkg::ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gllc_pkg::CTRL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_stall   = 1'b1;
      rsp_valid   = 1'b0;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      unique case (state_ff)
         gllc_pkg::CTRL_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = gllc_pkg::CTRL_EXEC;
            end
         end
         gllc_pkg::CTRL_EXEC: begin
            cmd.execute = 1'b1;
            state_in    = gllc_pkg::CTRL_RESP;
         end
         gllc_pkg::CTRL_RESP: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               state_in = gllc_pkg::CTRL_IDLE;
            end
         end
         default: begin
            state_in = gllc_pkg::CTRL_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

### rtl/gllc_datapath.sv
// per-line state, fault register, operation decode and result register
`timescale 1ns / 1ps
`default_nettype none
module gllc_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  gllc_pkg::cmd_type                cmd,
   input  logic [gllc_pkg::MODE_W-1:0]      req_mode,
   input  logic [gllc_pkg::IDX_W-1:0]       req_line_index,
   input  logic                             req_level_in,
   input  logic [gllc_pkg::BIAS_W-1:0]      req_bias_code,
   input  logic                             csr_write,
   input  logic signed [gllc_pkg::FAULT_W-1:0] csr_fault_line,
   output logic [gllc_pkg::STATUS_W-1:0]    rsp_status,
   output logic                             rsp_level_out,
   output logic                             rsp_irq_pulse,
   output logic [gllc_pkg::IDX_W-1:0]       rsp_irq_line
);

   localparam int N = gllc_pkg::NUM_LINES;

   // captured item
   logic [gllc_pkg::MODE_W-1:0] mode_ff;
   logic [gllc_pkg::IDX_W-1:0]  idx_ff;
   logic                        lv_ff;
   logic [gllc_pkg::BIAS_W-1:0] bias_ff;

   logic signed [gllc_pkg::FAULT_W-1:0] fault_ff;

   logic                        leased_ff [N];
   logic                        is_output_ff [N];
   logic                        level_ff [N];
   logic [gllc_pkg::BIAS_W-1:0] bias_state_ff [N];
   logic                        leased_in [N];
   logic                        is_output_in [N];
   logic                        level_in [N];
   logic [gllc_pkg::BIAS_W-1:0] bias_state_in [N];

   gllc_pkg::status_type        status_ff, status_in;
   logic                        lout_ff, lout_in;
   logic                        pulse_ff, pulse_in;
   logic [gllc_pkg::IDX_W-1:0]  iline_ff, iline_in;

   logic [gllc_pkg::LINE_W-1:0] sel;
   logic                        in_range;
   logic                        faults;

   assign sel      = idx_ff[gllc_pkg::LINE_W-1:0];
   assign in_range = {1'b0, idx_ff} < (gllc_pkg::IDX_W+1)'(N);
   assign faults   = !fault_ff[gllc_pkg::FAULT_W-1]
                     && (fault_ff[gllc_pkg::IDX_W-1:0] == idx_ff);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff <= req_mode;
         idx_ff  <= req_line_index;
         lv_ff   <= req_level_in;
         bias_ff <= req_bias_code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fault_ff <= '1;
      end else if (csr_write) begin
         fault_ff <= csr_fault_line;
      end
   end

   always_comb begin
      leased_in     = leased_ff;
      is_output_in  = is_output_ff;
      level_in      = level_ff;
      bias_state_in = bias_state_ff;
      status_in     = gllc_pkg::ST_OK;
      lout_in       = 1'b0;
      pulse_in      = 1'b0;
      iline_in      = '0;
      if (!in_range) begin
         status_in = gllc_pkg::ST_RANGE;
      end else begin
         unique case (mode_ff) inside
            gllc_pkg::MODE_REQUEST: begin
               if (leased_ff[sel]) begin
                  status_in = gllc_pkg::ST_BUSY;
               end else if (faults) begin
                  status_in = gllc_pkg::ST_FAULT;
               end else begin
                  leased_in[sel] = 1'b1;
               end
            end
            gllc_pkg::MODE_RELEASE: begin
               leased_in[sel]     = 1'b0;
               is_output_in[sel]  = 1'b0;
               level_in[sel]      = 1'b0;
               bias_state_in[sel] = '0;
            end
            gllc_pkg::MODE_INJECT: begin
               if (!leased_ff[sel] || is_output_ff[sel]) begin
                  status_in = gllc_pkg::ST_BUSY;
               end else begin
                  level_in[sel] = !level_ff[sel];
                  pulse_in      = 1'b1;
                  iline_in      = idx_ff;
               end
            end
            gllc_pkg::MODE_DIR_IN, gllc_pkg::MODE_DIR_OUT, gllc_pkg::MODE_GET,
            gllc_pkg::MODE_SET, gllc_pkg::MODE_SET_BIAS, gllc_pkg::MODE_DEBOUNCE: begin
               if (faults) begin
                  status_in = gllc_pkg::ST_FAULT;
               end else begin
                  case (mode_ff)
                     gllc_pkg::MODE_DIR_IN: begin
                        is_output_in[sel] = 1'b0;
                     end
                     gllc_pkg::MODE_DIR_OUT: begin
                        level_in[sel]     = lv_ff;
                        is_output_in[sel] = 1'b1;
                     end
                     gllc_pkg::MODE_GET: begin
                        lout_in = level_ff[sel];
                     end
                     gllc_pkg::MODE_SET: begin
                        if (!is_output_ff[sel]) begin
                           status_in = gllc_pkg::ST_PERM;
                        end else begin
                           level_in[sel] = lv_ff;
                        end
                     end
                     gllc_pkg::MODE_SET_BIAS: begin
                        bias_state_in[sel] = bias_ff;
                     end
                     default: begin
                        // debounce: fault check only
                     end
                  endcase
               end
            end
            default: begin
               status_in = gllc_pkg::ST_PERM;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < N; i++) begin
            leased_ff[i]     <= 1'b0;
            is_output_ff[i]  <= 1'b0;
            level_ff[i]      <= 1'b0;
            bias_state_ff[i] <= '0;
         end
      end else if (cmd.execute) begin
         leased_ff     <= leased_in;
         is_output_ff  <= is_output_in;
         level_ff      <= level_in;
         bias_state_ff <= bias_state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         status_ff <= status_in;
         lout_ff   <= lout_in;
         pulse_ff  <= pulse_in;
         iline_ff  <= iline_in;
      end
   end

   assign rsp_status    = status_ff;
   assign rsp_level_out = lout_ff;
   assign rsp_irq_pulse = pulse_ff;
   assign rsp_irq_line  = iline_ff;

endmodule
`default_nettype wire

### rtl/gpio_line_lease_controller.sv
// top level of the gpio line lease controller
//
//   channel   direction  handshake          payload
//   req_      in         valid / stall      mode, line_index, level_in, bias_code
//   rsp_      out        valid / stall      status, level_out, irq_pulse, irq_line
//   csr_      in         valid / ready      fault_line
//
// each item passes through capture, execute and present, and stays in present while the output stalls
// one item in flight at a time, set by the three-state sequencer in gllc_ctrl
// per-line state lives in flops and is read and written in the execute cycle
// synchronous reset clears all line state and sets fault_line to -1 (none)
// req_stall stays high from capture until the result transfer completes
`timescale 1ns / 1ps
`default_nettype none
`include "gpio_line_lease_controller_defines.svh"
module gpio_line_lease_controller (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [gllc_pkg::MODE_W-1:0]          req_mode,
   input  logic [gllc_pkg::IDX_W-1:0]           req_line_index,
   input  logic                                 req_level_in,
   input  logic [gllc_pkg::BIAS_W-1:0]          req_bias_code,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [gllc_pkg::STATUS_W-1:0]        rsp_status,
   output logic                                 rsp_level_out,
   output logic                                 rsp_irq_pulse,
   output logic [gllc_pkg::IDX_W-1:0]           rsp_irq_line,
   // configuration channel
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic signed [gllc_pkg::FAULT_W-1:0]  csr_fault_line
);

   gllc_pkg::cmd_type cmd;
   logic              csr_write;

   // fault register takes a write in any cycle
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   gllc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   gllc_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_mode       (req_mode),
      .req_line_index (req_line_index),
      .req_level_in   (req_level_in),
      .req_bias_code  (req_bias_code),
      .csr_write      (csr_write),
      .csr_fault_line (csr_fault_line),
      .rsp_status     (rsp_status),
      .rsp_level_out  (rsp_level_out),
      .rsp_irq_pulse  (rsp_irq_pulse),
      .rsp_irq_line   (rsp_irq_line)
   );

   // no new request while a result is pending
   `GLLC_ASSERT_NOW(a_single_item, clock, reset, rsp_valid, req_stall, "request taken with result pending")
   // a request transfer is followed by the execute cycle, never a result
   `GLLC_ASSERT_NEXT(a_exec_gap, clock, reset, req_valid && !req_stall, !rsp_valid && req_stall, "result shown without execute cycle")
   // interrupt pulse only on a successful inject
   `GLLC_ASSERT_NOW(a_irq_ok, clock, reset, rsp_valid && rsp_irq_pulse, rsp_status == gllc_pkg::ST_OK && rsp_level_out == 1'b0, "irq pulse with bad status")
   // level returned only on success
   `GLLC_ASSERT_NOW(a_level_ok, clock, reset, rsp_valid && rsp_level_out, rsp_status == gllc_pkg::ST_OK, "level returned on failed operation")
   // irq line is zero when no pulse
   `GLLC_ASSERT_NOW(a_irq_line_zero, clock, reset, rsp_valid && !rsp_irq_pulse, rsp_irq_line == '0, "irq line set without pulse")

endmodule
`default_nettype wire
